// File: hw/rtl/gcode_nybble_unpacker_unit_defines.svh
// Assertion macros shared by the G-code nybble unpacker RTL.
`ifndef GCODE_NYBBLE_UNPACKER_UNIT_DEFINES_SVH
`define GCODE_NYBBLE_UNPACKER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define GNUP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GNUP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gnup_pkg.sv
// Package with the types, constants and decode functions of the nybble unpacker.
`timescale 1ns / 1ps

package gnup_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] ESC_BYTE        = 8'hFF;
    localparam logic [7:0] CMD_NOSPACE_OFF = 8'hF6;
    localparam logic [7:0] CMD_NOSPACE_ON  = 8'hF7;
    localparam logic [7:0] CMD_QUERY       = 8'hF8;
    localparam logic [7:0] CMD_RESET       = 8'hF9;
    localparam logic [7:0] CMD_PACK_OFF    = 8'hFA;
    localparam logic [7:0] CMD_PACK_ON     = 8'hFB;

    localparam logic [3:0] NIB_SPACE   = 4'hB;
    localparam logic [3:0] NIB_LITERAL = 4'hF;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] SUBST_RESET  = 8'd69;

    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Decoder state that one byte may change.
    typedef struct packed {
        logic [1:0] lit_due;
        logic       held_valid;
        logic [7:0] held_char;
    } dec_state_t;

    // Result of decoding one byte: new state and up to two characters.
    typedef struct packed {
        dec_state_t st;
        logic [1:0] n;
        logic [7:0] c0;
        logic [7:0] c1;
    } dec_res_t;

    // One queued word group: all results caused by one input byte.
    typedef struct packed {
        logic            kind;
        logic [2:0]      count;
        logic [3:0][7:0] chars;
        logic            packing;
        logic            nospace;
    } entry_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] map_nyb(input logic [3:0] nib, input logic subst,
                                           input logic [7:0] sub);
        logic [7:0] ch;
        case (nib)
            4'h0: ch = "0";
            4'h1: ch = "1";
            4'h2: ch = "2";
            4'h3: ch = "3";
            4'h4: ch = "4";
            4'h5: ch = "5";
            4'h6: ch = "6";
            4'h7: ch = "7";
            4'h8: ch = "8";
            4'h9: ch = "9";
            4'hA: ch = ".";
            4'hB: ch = subst ? sub : " ";
            4'hC: ch = CHAR_NEWLINE;
            4'hD: ch = "G";
            4'hE: ch = "X";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic dec_res_t decode_byte(input dec_state_t s, input logic packing,
                                             input logic subst, input logic [7:0] sub,
                                             input logic [7:0] c);
        dec_res_t   r;
        logic [7:0] first;
        logic [7:0] second;
        r      = '0;
        r.st   = s;
        first  = map_nyb(c[3:0], subst, sub);
        second = map_nyb(c[7:4], subst, sub);
        if (!packing)
        begin
            r.n  = 2'd1;
            r.c0 = c;
        end
        else if (s.lit_due != 2'd0)
        begin
            r.n  = 2'd1;
            r.c0 = c;
            if (s.held_valid)
            begin
                r.n             = 2'd2;
                r.c1            = s.held_char;
                r.st.held_valid = 1'b0;
            end
            r.st.lit_due = s.lit_due - 2'd1;
        end
        else if (c[3:0] == NIB_LITERAL)
        begin
            if (c[7:4] == NIB_LITERAL)
            begin
                r.st.lit_due = 2'd2;
            end
            else
            begin
                r.st.lit_due    = 2'd1;
                r.st.held_char  = second;
                r.st.held_valid = 1'b1;
            end
        end
        else
        begin
            r.n  = 2'd1;
            r.c0 = first;
            if (first != CHAR_NEWLINE)
            begin
                if (c[7:4] == NIB_LITERAL)
                begin
                    r.st.lit_due = 2'd1;
                end
                else
                begin
                    r.n  = 2'd2;
                    r.c1 = second;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/gnup_front.sv
// Front end: accepts serial bytes, tracks escape and command state, decodes into queue entries.
`timescale 1ns / 1ps

module gnup_front
    import gnup_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  q_status_t  q_status,
    output logic       push,
    output entry_t     push_entry
);

    logic       packing_reg, packing_next;
    logic       nospace_reg, nospace_next;
    logic       subst_reg, subst_next;
    logic       escape_reg, escape_next;
    logic       cmd_pend_reg, cmd_pend_next;
    dec_state_t dec_reg, dec_next;
    logic [7:0] sub_reg;

    dec_res_t   res_esc;
    dec_res_t   res_byte;
    dec_state_t st_mid;
    logic [1:0] n_esc;
    logic       accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // A lone escape byte is decoded first, then the byte that follows it.
    assign res_esc  = decode_byte(dec_reg, packing_reg, subst_reg, sub_reg, ESC_BYTE);
    assign st_mid   = escape_reg ? res_esc.st : dec_reg;
    assign n_esc    = escape_reg ? res_esc.n : 2'd0;
    assign res_byte = decode_byte(st_mid, packing_reg, subst_reg, sub_reg, rx_byte);

    always_comb
    begin
        packing_next  = packing_reg;
        nospace_next  = nospace_reg;
        subst_next    = subst_reg;
        escape_next   = escape_reg;
        cmd_pend_next = cmd_pend_reg;
        dec_next      = dec_reg;
        push          = 1'b0;
        push_entry    = '0;
        if (accept)
        begin
            if (rx_byte == ESC_BYTE)
            begin
                if (escape_reg)
                begin
                    cmd_pend_next = 1'b1;
                    escape_next   = 1'b0;
                end
                else
                begin
                    escape_next = 1'b1;
                end
            end
            else if (cmd_pend_reg)
            begin
                cmd_pend_next = 1'b0;
                case (rx_byte)
                    CMD_PACK_ON:     packing_next = 1'b1;
                    CMD_PACK_OFF:    packing_next = 1'b0;
                    CMD_RESET:
                    begin
                        packing_next  = 1'b0;
                        nospace_next  = 1'b0;
                        escape_next   = 1'b0;
                        dec_next      = '0;
                    end
                    CMD_NOSPACE_ON:
                    begin
                        nospace_next = 1'b1;
                        subst_next   = 1'b1;
                    end
                    CMD_NOSPACE_OFF:
                    begin
                        nospace_next = 1'b0;
                        subst_next   = 1'b0;
                    end
                    CMD_QUERY:       packing_next = packing_reg;
                    default:         packing_next = packing_reg;
                endcase
                push               = 1'b1;
                push_entry.kind    = KIND_REPORT;
                push_entry.count   = 3'd1;
                push_entry.packing = packing_next;
                push_entry.nospace = nospace_next;
            end
            else
            begin
                escape_next        = 1'b0;
                dec_next           = res_byte.st;
                push_entry.kind    = KIND_CHAR;
                push_entry.count   = {1'b0, n_esc} + {1'b0, res_byte.n};
                push_entry.packing = packing_reg;
                push_entry.nospace = nospace_reg;
                case (n_esc)
                    2'd0:
                    begin
                        push_entry.chars[0] = res_byte.c0;
                        push_entry.chars[1] = res_byte.c1;
                    end
                    2'd1:
                    begin
                        push_entry.chars[0] = res_esc.c0;
                        push_entry.chars[1] = res_byte.c0;
                        push_entry.chars[2] = res_byte.c1;
                    end
                    default:
                    begin
                        push_entry.chars[0] = res_esc.c0;
                        push_entry.chars[1] = res_esc.c1;
                        push_entry.chars[2] = res_byte.c0;
                        push_entry.chars[3] = res_byte.c1;
                    end
                endcase
                push = (push_entry.count != 3'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packing_reg  <= 1'b0;
            nospace_reg  <= 1'b0;
            subst_reg    <= 1'b0;
            escape_reg   <= 1'b0;
            cmd_pend_reg <= 1'b0;
            dec_reg      <= '0;
            sub_reg      <= SUBST_RESET;
        end
        else
        begin
            packing_reg  <= packing_next;
            nospace_reg  <= nospace_next;
            subst_reg    <= subst_next;
            escape_reg   <= escape_next;
            cmd_pend_reg <= cmd_pend_next;
            dec_reg      <= dec_next;
            if (cfg_wr_en)
            begin
                sub_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: hw/rtl/gnup_queue.sv
// Short queue of decoded word groups between the front and the back.
`timescale 1ns / 1ps

module gnup_queue
    import gnup_pkg::*;
#(
    parameter int unsigned Depth = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head_entry,
    output q_status_t q_status
);

`include "gcode_nybble_unpacker_unit_defines.svh"

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    entry_t            slots [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == CntW'(Depth));
    assign q_status.empty = (count_reg == '0);
    assign head_entry     = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `GNUP_ASSERT_IMPLY(a_no_push_when_full, push, !q_status.full, "push into a full queue")
    `GNUP_ASSERT_IMPLY(a_no_pop_when_empty, pop, !q_status.empty, "pop from an empty queue")
    `GNUP_ASSERT_IMPLY(a_push_nonempty_group, push, push_entry.count != 3'd0, "empty group queued")

endmodule

// File: hw/rtl/gnup_back.sv
// Back end: sends the words of the head queue entry one per cycle while out_stall is low.
`timescale 1ns / 1ps

module gnup_back
    import gnup_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head_entry,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_char,
    output logic       packing_on,
    output logic       nospace_on,
    output logic       last
);

`include "gcode_nybble_unpacker_unit_defines.svh"

    logic [1:0] idx_reg, idx_next;
    logic       accept;

    assign out_valid  = !q_status.empty;
    assign kind       = head_entry.kind;
    assign out_char   = head_entry.chars[idx_reg];
    assign packing_on = head_entry.packing;
    assign nospace_on = head_entry.nospace;
    assign last       = (({1'b0, idx_reg} + 3'd1) == head_entry.count);
    assign accept     = out_valid && !out_stall;
    assign pop        = accept && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    `GNUP_ASSERT_IMPLY(a_report_single, out_valid && kind == KIND_REPORT,
                       last && out_char == 8'h00, "report word is not a single zero word")
    `GNUP_ASSERT_IMPLY(a_index_in_group, out_valid, {1'b0, idx_reg} < head_entry.count,
                       "word index beyond its group")
    `GNUP_ASSERT_ALWAYS(a_index_idle_zero, out_valid || idx_reg == 2'd0,
                        "word index left non-zero with nothing queued")

endmodule

// File: hw/rtl/gcode_nybble_unpacker_unit.sv
// Top level of the G-code nybble unpacker: front decoder, word queue and output sender.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    rx_byte
//  output    out        out_valid / out_stall  kind, out_char, packing_on, nospace_on, last
//  config    in         cfg_wr_en              cfg_wr_data (space substitute character)
//
// The front takes one byte in every cycle in which the queue has room, and works out all
// words that the byte causes in that same cycle. The sender then hands out one word per
// cycle while out_stall is low; a packed byte gives up to two words. Bytes that cause
// no word never enter the queue. Reset clears every flag, empties the queue and sets the
// substitute character to 'E'. Stalls on either side are absorbed by the queue.

module gcode_nybble_unpacker_unit
    import gnup_pkg::*;
#(
    parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] out_char,
    output logic       packing_on,
    output logic       nospace_on,
    output logic       last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    // Queue status is shared by both halves: the front stalls on full, the back idles on empty.
    q_status_t q_status;
    entry_t    push_entry;
    entry_t    head_entry;
    logic      push;
    logic      pop;

    // The front owns all decoder state, including the substitute character register.
    gnup_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Each queue entry carries every word caused by one byte, so ordering is preserved.
    gnup_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // The back releases the head entry once its final word has been taken.
    gnup_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_char   (out_char),
        .packing_on (packing_on),
        .nospace_on (nospace_on),
        .last       (last)
    );

endmodule
